// File: hdl/sorted_deadline_queue_macros.svh
// Assertion macros shared by the sorted deadline queue RTL.
`ifndef SORTED_DEADLINE_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SDQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted deadline queue: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted deadline queue: next-cycle check failed");

`endif

// File: hdl/sdq_pkg.sv
// Types and constants of the sorted deadline queue.
package sdq_pkg;

  localparam int DATA_W  = 64;
  localparam int CMD_W   = 2;
  localparam int COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

  // Reported as the earliest deadline when the store is empty
  localparam logic [DATA_W-1:0] DEADLINE_NONE = {DATA_W{1'b1}};

  // Stored pair; packed order makes one wide compare give the sort key
  typedef struct packed {
    logic [DATA_W-1:0] deadline;
    logic [DATA_W-1:0] task_id;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] deadline;
    logic [DATA_W-1:0] task_id;
    logic [DATA_W-1:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic               done_res;
    logic               full_res;
    logic [DATA_W-1:0]  popped_task;
    logic [DATA_W-1:0]  head_deadline;
    logic [COUNT_W-1:0] count;
  } out_item_t;

endpackage

// File: hdl/sdq_in_if.sv
// Command channel of the sorted deadline queue.
interface sdq_in_if;
  import sdq_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sdq_out_if.sv
// Result channel of the sorted deadline queue.
interface sdq_out_if;
  import sdq_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sorted_deadline_queue.sv
// Top level of the sorted deadline queue: sequencer over an entry store with one write and one read port.
//
//   channel  direction  transfer carries
//   in_ch    sink       command, deadline, task_id, current_time
//   out_ch   source     done_res, full_res, popped_task, head_deadline, count
//
// Add: compares from the top slot down, moving each larger entry up one slot, then writes
// the new entry; an empty or full store skips the compare. Remove, pop: scan from slot 0,
// one store read and write per cycle. An unused command goes straight to the head read.
// Every command ends with a read of slot 0, when not empty, to refresh the head deadline.
// Reset clears only the count and the control; the store needs no clearing pass.
// in_ch is ready only between commands; a held result stalls the final step.
`include "sorted_deadline_queue_macros.svh"

module sorted_deadline_queue #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  sdq_in_if.sink    in_ch,
  sdq_out_if.source out_ch
);
  import sdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  typedef enum logic [2:0] {
    IDLE,
    ADD_CMP,
    ADD_PUT,
    SCAN,
    HEAD_RD,
    HEAD_WAIT
  } state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    pos;
  logic             dv;
  logic [AW-1:0]    di;
  logic             found;
  logic [CMD_W-1:0] cmd_r;
  entry_t           key_r;
  logic [DATA_W-1:0] now_r;
  logic             done_r;
  logic             full_r;
  logic [DATA_W-1:0] popped_r;
  logic             out_valid;
  out_item_t        out_data;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  logic          accept;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] pos_m2;
  logic [AW-1:0] di_m1;
  logic          gt;
  logic          hit;

  sdq_entry_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign cnt_m1 = cnt - ONE_C;
  assign pos_m2 = pos - TWO_C;
  assign di_m1  = di - AW'(1);

  // Compares on the read data: key order for add, task match for remove, head due test for pop
  assign gt  = rdata > key_r;
  assign hit = (cmd_r == CMD_POP) ? (di == '0 && rdata.deadline <= now_r)
                                  : (rdata.task_id == key_r.task_id);

  // Store port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = key_r;
    re    = 1'b0;
    raddr = '0;
    unique case (state)
      IDLE: begin
        if (accept && in_ch.data.command == CMD_ADD && cnt < CAP_C) begin
          if (cnt == '0) begin
            we    = 1'b1;
            wdata = '{deadline: in_ch.data.deadline, task_id: in_ch.data.task_id};
          end else begin
            re    = 1'b1;
            raddr = cnt_m1[AW-1:0];
          end
        end
      end
      ADD_CMP: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
        if (gt) begin
          wdata = rdata;
          if (pos != ONE_C) begin
            re    = 1'b1;
            raddr = pos_m2[AW-1:0];
          end
        end
      end
      ADD_PUT: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
      end
      SCAN: begin
        if (pos < cnt) begin
          re    = 1'b1;
          raddr = pos[AW-1:0];
        end
        if (dv && found) begin
          we    = 1'b1;
          waddr = di_m1;
          wdata = rdata;
        end
      end
      HEAD_RD: begin
        re = (cnt != '0);
      end
      HEAD_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      dv        <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != HEAD_WAIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            cmd_r    <= in_ch.data.command;
            key_r    <= '{deadline: in_ch.data.deadline, task_id: in_ch.data.task_id};
            now_r    <= in_ch.data.current_time;
            done_r   <= 1'b0;
            full_r   <= 1'b0;
            popped_r <= '0;
            found    <= 1'b0;
            dv       <= 1'b0;
            pos      <= '0;
            unique case (in_ch.data.command)
              CMD_ADD: begin
                if (cnt >= CAP_C) begin
                  full_r <= 1'b1;
                  state  <= HEAD_RD;
                end else if (cnt == '0) begin
                  cnt    <= ONE_C;
                  done_r <= 1'b1;
                  state  <= HEAD_RD;
                end else begin
                  pos   <= cnt;
                  state <= ADD_CMP;
                end
              end
              CMD_REMOVE, CMD_POP: begin
                state <= SCAN;
              end
              default: begin
                state <= HEAD_RD;
              end
            endcase
          end
        end
        ADD_CMP: begin
          // move the larger entry up, or drop the new one in place
          if (gt) begin
            pos <= pos - ONE_C;
            if (pos == ONE_C) begin
              state <= ADD_PUT;
            end
          end else begin
            cnt    <= cnt + ONE_C;
            done_r <= 1'b1;
            state  <= HEAD_RD;
          end
        end
        ADD_PUT: begin
          cnt    <= cnt + ONE_C;
          done_r <= 1'b1;
          state  <= HEAD_RD;
        end
        SCAN: begin
          // stream reads up the store; after a hit each entry shifts down one
          if (pos < cnt) begin
            pos <= pos + ONE_C;
            dv  <= 1'b1;
            di  <= pos[AW-1:0];
          end else begin
            dv <= 1'b0;
          end
          if (dv && !found && hit) begin
            found <= 1'b1;
            if (cmd_r == CMD_POP) begin
              popped_r <= rdata.task_id;
            end
          end
          if (pos == cnt && !dv) begin
            if (found) begin
              cnt    <= cnt_m1;
              done_r <= 1'b1;
            end
            state <= HEAD_RD;
          end
        end
        HEAD_RD: begin
          state <= HEAD_WAIT;
        end
        HEAD_WAIT: begin
          // hold until the result register is free
          if (!out_valid || out_ch.ready) begin
            out_data.done_res      <= done_r;
            out_data.full_res      <= full_r;
            out_data.popped_task   <= popped_r;
            out_data.head_deadline <= (cnt != '0) ? rdata.deadline : DEADLINE_NONE;
            out_data.count         <= COUNT_W'(cnt);
            out_valid              <= 1'b1;
            state                  <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `SDQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !in_ch.ready)
  `SDQ_ASSERT_NEXT(a_result_drains, clk, rst,
                   out_valid && out_ch.ready && state != HEAD_WAIT, !out_valid)
  `SDQ_ASSERT_NEXT(a_count_step, clk, rst, 1'b1,
                   cnt == $past(cnt) || cnt == $past(cnt) + ONE_C || cnt + ONE_C == $past(cnt))
  `SDQ_ASSERT_IMPLIES(a_shift_in_range, clk, rst, state == SCAN && dv && found,
                      di != '0 && cnt <= CAP_C)

endmodule

// File: hdl/sdq_entry_ram.sv
// Entry store: one write port and one read port with registered read data.
module sdq_entry_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  sdq_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output sdq_pkg::entry_t rdata
);
  import sdq_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
